/* hw/rtl/tuh_pkg.sv */
package tuh_pkg;

  // Command codes carried by an input transaction.
  localparam logic [1:0] CMD_HEADER = 2'd0;
  localparam logic [1:0] CMD_ITEM   = 2'd1;
  localparam logic [1:0] CMD_FOLLOW = 2'd2;
  localparam logic [1:0] CMD_TICK   = 2'd3;

  // Autopilot status codes.
  localparam logic [1:0] STATUS_SUCCEED   = 2'd0;
  localparam logic [1:0] STATUS_EXECUTING = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  // Acknowledge codes.
  localparam logic [1:0] ACK_OK        = 2'd0;
  localparam logic [1:0] ACK_BUSY      = 2'd1;
  localparam logic [1:0] ACK_IDX_ERR   = 2'd2;
  localparam logic [1:0] ACK_LIST_EMPTY = 2'd3;

  // Axis codes.
  localparam logic [1:0] AXIS_X   = 2'd0;
  localparam logic [1:0] AXIS_Y   = 2'd1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] AXIS_YAW = 2'd3;

  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] IDLE_MAX      = 16'hFFFF;

  typedef struct packed {
    logic [1:0] cmd;
    logic [7:0] segment_count;
    logic       z_axis_on;
    logic       yaw_axis_on;
    logic [7:0] segment_index;
    logic [1:0] axis_kind;
    logic       stop_request;
    logic       loop_option;
    logic [1:0] autopilot_status;
  } in_item_t;

  typedef struct packed {
    logic       ack_valid;
    logic [1:0] ack_code;
    logic       store_valid;
    logic [1:0] store_axis;
    logic [7:0] store_slot;
    logic       abort_config;
    logic       follow_valid;
    logic       follow_stop;
    logic       follow_loop;
    logic       receiving_now;
    logic       upload_done;
    logic [7:0] expected_index;
  } out_item_t;

endpackage

/* hw/rtl/tuh_core.sv */
module tuh_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step_en,
  input  tuh_pkg::in_item_t item,
  input  logic [15:0]       timeout_ticks,
  output tuh_pkg::out_item_t result
);

  logic        open_r, open_nxt;
  logic        done_r, done_nxt;
  logic        z_use_r, z_use_nxt;
  logic        yaw_use_r, yaw_use_nxt;
  logic [7:0]  count_r, count_nxt;
  logic [7:0]  next_seg_r, next_seg_nxt;
  logic [3:0]  seen_r, seen_nxt;
  logic [15:0] idle_r, idle_nxt;

  always_comb begin
    logic [3:0]  seen_set;
    logic        seg_complete;
    logic [15:0] idle_inc;

    open_nxt     = open_r;
    done_nxt     = done_r;
    z_use_nxt    = z_use_r;
    yaw_use_nxt  = yaw_use_r;
    count_nxt    = count_r;
    next_seg_nxt = next_seg_r;
    seen_nxt     = seen_r;
    idle_nxt     = idle_r;
    result       = '0;

    seen_set     = seen_r | (4'b0001 << item.axis_kind);
    seg_complete = seen_set[tuh_pkg::AXIS_X] && seen_set[tuh_pkg::AXIS_Y] &&
                   (seen_set[tuh_pkg::AXIS_Z] || !z_use_r) &&
                   (seen_set[tuh_pkg::AXIS_YAW] || !yaw_use_r);
    idle_inc     = (idle_r < tuh_pkg::IDLE_MAX) ? idle_r + 16'd1 : idle_r;

    case (item.cmd)
      tuh_pkg::CMD_HEADER: begin
        idle_nxt     = '0;
        z_use_nxt    = item.z_axis_on;
        yaw_use_nxt  = item.yaw_axis_on;
        count_nxt    = item.segment_count;
        seen_nxt     = '0;
        done_nxt     = 1'b0;
        open_nxt     = 1'b1;
        next_seg_nxt = '0;
        if (item.autopilot_status == tuh_pkg::STATUS_SUCCEED) begin
          result.ack_valid = 1'b1;
          result.ack_code  = tuh_pkg::ACK_OK;
        end else if (item.autopilot_status == tuh_pkg::STATUS_EXECUTING) begin
          result.ack_valid = 1'b1;
          result.ack_code  = tuh_pkg::ACK_BUSY;
        end
      end
      tuh_pkg::CMD_ITEM: begin
        if (open_r) begin
          idle_nxt = '0;
          if (item.segment_index != next_seg_r) begin
            result.ack_valid = 1'b1;
            result.ack_code  = tuh_pkg::ACK_IDX_ERR;
          end else begin
            result.store_valid = 1'b1;
            result.store_axis  = item.axis_kind;
            result.store_slot  = next_seg_r;
            if (item.autopilot_status == tuh_pkg::STATUS_SUCCEED) begin
              result.ack_valid = 1'b1;
              result.ack_code  = tuh_pkg::ACK_OK;
            end else if (item.autopilot_status == tuh_pkg::STATUS_EXECUTING) begin
              result.ack_valid = 1'b1;
              result.ack_code  = tuh_pkg::ACK_BUSY;
            end
            if (seg_complete) begin
              next_seg_nxt = next_seg_r + 8'd1;
              seen_nxt     = '0;
            end else begin
              seen_nxt = seen_set;
            end
            if (next_seg_nxt >= count_r) begin
              done_nxt = 1'b1;
            end
          end
        end
      end
      tuh_pkg::CMD_FOLLOW: begin
        result.follow_valid = 1'b1;
        result.follow_stop  = item.stop_request;
        result.follow_loop  = !item.stop_request && item.loop_option;
        case (item.autopilot_status)
          tuh_pkg::STATUS_SUCCEED: begin
            result.ack_valid = 1'b1;
            result.ack_code  = tuh_pkg::ACK_OK;
          end
          tuh_pkg::STATUS_EXECUTING: begin
            result.ack_valid = 1'b1;
            result.ack_code  = tuh_pkg::ACK_BUSY;
          end
          tuh_pkg::STATUS_EMPTY: begin
            result.ack_valid = 1'b1;
            result.ack_code  = tuh_pkg::ACK_LIST_EMPTY;
          end
          default: begin
            result.ack_valid = 1'b0;
          end
        endcase
      end
      default: begin
        // Time tick: only an open or finished session counts silence.
        if (open_r || done_r) begin
          idle_nxt = idle_inc;
          if (idle_inc >= timeout_ticks) begin
            result.abort_config = !done_r;
            open_nxt     = 1'b0;
            done_nxt     = 1'b0;
            z_use_nxt    = 1'b0;
            yaw_use_nxt  = 1'b0;
            count_nxt    = '0;
            next_seg_nxt = '0;
            seen_nxt     = '0;
            idle_nxt     = '0;
          end
        end
      end
    endcase

    result.receiving_now  = open_nxt;
    result.upload_done    = done_nxt;
    result.expected_index = next_seg_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r     <= 1'b0;
      done_r     <= 1'b0;
      z_use_r    <= 1'b0;
      yaw_use_r  <= 1'b0;
      count_r    <= '0;
      next_seg_r <= '0;
      seen_r     <= '0;
      idle_r     <= '0;
    end else if (step_en) begin
      open_r     <= open_nxt;
      done_r     <= done_nxt;
      z_use_r    <= z_use_nxt;
      yaw_use_r  <= yaw_use_nxt;
      count_r    <= count_nxt;
      next_seg_r <= next_seg_nxt;
      seen_r     <= seen_nxt;
      idle_r     <= idle_nxt;
    end
  end

endmodule

/* hw/rtl/trajectory_upload_handshake.sv */
// An accepted input transaction passes through the input register and then the result
// register before out_valid. Throughput: one transaction per cycle while out_ready stays
// high; the input register and the result register each advance whenever the stage after
// them is empty or drained in the same cycle.
// Reset (rst_n low at a clock edge): the session state clears, both stages empty,
// and the timeout register returns to 5000 ticks.
module trajectory_upload_handshake (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tuh_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tuh_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [15:0]        cfg_wdata
);

  // Timeout register. SW must write it only while no transaction is in flight; unchecked.
  logic [15:0] timeout_r;

  // Input register stage.
  logic              s1_valid_r;
  tuh_pkg::in_item_t s1_item_r;

  // Result register stage.
  logic               out_valid_r;
  tuh_pkg::out_item_t out_item_r;
  tuh_pkg::out_item_t step_result;

  logic out_adv;
  logic step_en;

  // The result register can take a new transaction when it is empty or being drained.
  assign out_adv  = !out_valid_r || out_ready;
  // The session state advances exactly when a transaction moves into the result register.
  assign step_en  = s1_valid_r && out_adv;
  assign in_ready = !s1_valid_r || out_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= tuh_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_data;
    end
    if (step_en) begin
      out_item_r <= step_result;
    end
  end

  // Session state and the per-transaction decision logic.
  tuh_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (step_en),
    .item          (s1_item_r),
    .timeout_ticks (timeout_r),
    .result        (step_result)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
